// ===== sv/dpc_pkg.sv =====
// Shared types and constants for the dark pixel centroid block.
// No dependencies; every other file but dpc_stream_if uses its scoped names.
`default_nettype none

package dpc_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 6;
  localparam int ORIGIN_W   = 10;
  localparam int CENTER_W   = 11;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int STEP_W     = $clog2(SUM_W);

  // Side of the square region; a coordinate at or beyond it is not counted.
  localparam int REGION_SIDE = 64;
  // Dark pixel count saturates here so the sums never wrap.
  localparam int MAX_HITS    = 4096;

  localparam logic [PIX_W-1:0] THRESH_RESET = PIX_W'(2);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = CFG_IDX_W'(2);

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_value;
    logic [COORD_W-1:0] col_in_region;
    logic [COORD_W-1:0] row_in_region;
    logic               last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic                found;
    logic [CNT_W-1:0]    dark_count;
  } centroid_t;

  typedef struct packed {
    logic take;
    logic clear;
  } accum_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/dpc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is a parameter; used with types from dpc_pkg.
`default_nettype none

interface dpc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/dpc_accum.sv =====
// Running column/row sums and dark pixel count for one region scan.
// Depends on dpc_pkg.
`default_nettype none

module dpc_accum (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dpc_pkg::accum_ctl_t        ctl,
  input  wire dpc_pkg::pixel_t            pixel,
  input  wire logic [dpc_pkg::PIX_W-1:0]  threshold,
  output logic      [dpc_pkg::SUM_W-1:0]  col_sum,
  output logic      [dpc_pkg::SUM_W-1:0]  row_sum,
  output logic      [dpc_pkg::CNT_W-1:0]  hit_count
);

  localparam int SIDE_W = $clog2(dpc_pkg::REGION_SIDE + 1) + 1;

  logic in_col;
  logic in_row;
  logic room;
  logic dark;

  // Coordinates compared at a width that holds the region side itself
  assign in_col = (SIDE_W'(pixel.col_in_region) < SIDE_W'(dpc_pkg::REGION_SIDE));
  assign in_row = (SIDE_W'(pixel.row_in_region) < SIDE_W'(dpc_pkg::REGION_SIDE));
  assign room   = (hit_count < dpc_pkg::CNT_W'(dpc_pkg::MAX_HITS));
  assign dark   = (pixel.pixel_value < threshold) && in_col && in_row && room;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      col_sum   <= '0;
      row_sum   <= '0;
      hit_count <= '0;
    end else if (ctl.take && dark) begin
      col_sum   <= col_sum + dpc_pkg::SUM_W'(pixel.col_in_region);
      row_sum   <= row_sum + dpc_pkg::SUM_W'(pixel.row_in_region);
      hit_count <= hit_count + dpc_pkg::CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/dpc_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by both axes.
// Depends on dpc_pkg.
`default_nettype none

module dpc_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [dpc_pkg::SUM_W-1:0] dividend,
  input  wire logic [dpc_pkg::CNT_W-1:0] divisor,
  output dpc_pkg::div_stat_t             stat,
  output logic      [dpc_pkg::SUM_W-1:0] quotient
);

  localparam logic [dpc_pkg::STEP_W-1:0] LAST_STEP = dpc_pkg::STEP_W'(dpc_pkg::SUM_W - 1);

  logic [dpc_pkg::CNT_W-1:0]  rem;
  logic [dpc_pkg::CNT_W-1:0]  dsr;
  logic [dpc_pkg::SUM_W-1:0]  dvd;
  logic [dpc_pkg::STEP_W-1:0] step;
  logic                       busy;
  logic                       done;

  logic [dpc_pkg::CNT_W:0]    rem_sh;
  logic                       ge;
  logic [dpc_pkg::CNT_W-1:0]  rem_next;

  assign rem_sh   = {rem, dvd[dpc_pkg::SUM_W-1]};
  assign ge       = (rem_sh >= {1'b0, dsr});
  assign rem_next = ge ? dpc_pkg::CNT_W'(rem_sh - {1'b0, dsr}) : rem_sh[dpc_pkg::CNT_W-1:0];

  // dvd shifts out dividend bits at the top and takes quotient bits at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // one-cycle pulse after the final step
      done <= !start && busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        dsr  <= divisor;
        dvd  <= dividend;
        step <= '0;
      end else if (busy) begin
        rem  <= rem_next;
        dvd  <= {dvd[dpc_pkg::SUM_W-2:0], ge};
        step <= step + dpc_pkg::STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;

endmodule

`default_nettype wire

// ===== sv/dark_pixel_centroid_unit.sv =====
// Dark pixel centroid, top level: config registers, sequencer, output register.
// Depends on dpc_pkg, dpc_stream_if, dpc_accum, dpc_divider.
//
// Usage
//   pixels   : sink channel, one region pixel per transfer with its column and
//              row inside the region and a last flag on the final pixel.
//   centroid : source channel, one result per region (on the last pixel).
//   cfg_*    : write-only registers (threshold, origin x, origin y); write them
//              only while the block is idle.
// Throughput: pixels not marked last are taken one per cycle while the block is
//   idle. After the last pixel the block drops ready while one shared 18-step
//   divider runs twice (column sum, then row sum), making one quotient bit per
//   cycle; when no pixel was dark the divider is skipped and the result goes
//   straight to the output register.
// Stall: the result sits in an output register; the next region's pixels are
//   taken while it waits. A second result waits in the sequencer until the
//   register is free.
// Reset (rst, synchronous): sums and count cleared, output invalid, threshold
//   back to 2, origins to 0.
`default_nettype none

module dark_pixel_centroid_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data,
  dpc_stream_if.sink                          pixels,
  dpc_stream_if.source                        centroid
);

  typedef enum logic [2:0] {
    IDLE,
    LAUNCH_X,
    WAIT_X,
    WAIT_Y,
    EMIT
  } state_t;

  state_t state;

  // Configuration registers
  logic [dpc_pkg::PIX_W-1:0]    dark_threshold;
  logic [dpc_pkg::ORIGIN_W-1:0] origin_x;
  logic [dpc_pkg::ORIGIN_W-1:0] origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold <= dpc_pkg::THRESH_RESET;
      origin_x       <= '0;
      origin_y       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dpc_pkg::REG_THRESHOLD: dark_threshold <= cfg_data[dpc_pkg::PIX_W-1:0];
        dpc_pkg::REG_ORIGIN_X:  origin_x       <= cfg_data[dpc_pkg::ORIGIN_W-1:0];
        dpc_pkg::REG_ORIGIN_Y:  origin_y       <= cfg_data[dpc_pkg::ORIGIN_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Pixel side
  dpc_pkg::accum_ctl_t         acc_ctl;
  logic [dpc_pkg::SUM_W-1:0]   col_sum;
  logic [dpc_pkg::SUM_W-1:0]   row_sum;
  logic [dpc_pkg::CNT_W-1:0]   hit_count;
  logic                        in_xfer;
  logic                        slot_free;
  logic                        out_valid;
  dpc_pkg::centroid_t          out_data;

  assign pixels.ready = (state == IDLE) && !rst;
  assign in_xfer      = pixels.valid && pixels.ready;
  assign slot_free    = !out_valid || centroid.ready;

  assign acc_ctl.take  = in_xfer;
  assign acc_ctl.clear = (state == EMIT) && slot_free;

  dpc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .ctl       (acc_ctl),
    .pixel     (pixels.data),
    .threshold (dark_threshold),
    .col_sum   (col_sum),
    .row_sum   (row_sum),
    .hit_count (hit_count)
  );

  // Shared divider: column sum first, row sum on the cycle the first finishes
  dpc_pkg::div_stat_t        div_stat;
  logic [dpc_pkg::SUM_W-1:0] quotient;
  logic                      start_x;
  logic                      start_y;
  logic [dpc_pkg::SUM_W-1:0] dividend;
  logic                      any_hit;

  assign any_hit  = (hit_count != '0);
  assign start_x  = (state == LAUNCH_X) && any_hit;
  assign start_y  = (state == WAIT_X) && div_stat.done;
  assign dividend = start_y ? row_sum : col_sum;

  dpc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (start_x || start_y),
    .dividend (dividend),
    .divisor  (hit_count),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Quotients only need the bits that survive the 11-bit frame coordinate
  logic [dpc_pkg::CENTER_W-1:0] quot_x;
  logic [dpc_pkg::CENTER_W-1:0] quot_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // EMIT reloads the register itself when the old result leaves
      if (out_valid && centroid.ready && (state != EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_xfer && pixels.data.last_pixel) begin
            state <= LAUNCH_X;
          end
        end
        LAUNCH_X: begin
          state <= any_hit ? WAIT_X : EMIT;
        end
        WAIT_X: begin
          if (div_stat.done) begin
            quot_x <= quotient[dpc_pkg::CENTER_W-1:0];
            state  <= WAIT_Y;
          end
        end
        WAIT_Y: begin
          if (div_stat.done) begin
            quot_y <= quotient[dpc_pkg::CENTER_W-1:0];
            state  <= EMIT;
          end
        end
        EMIT: begin
          if (slot_free) begin
            out_valid           <= 1'b1;
            out_data.found      <= any_hit;
            out_data.dark_count <= hit_count;
            if (any_hit) begin
              out_data.center_x <= quot_x + dpc_pkg::CENTER_W'(origin_x);
              out_data.center_y <= quot_y + dpc_pkg::CENTER_W'(origin_y);
            end else begin
              // empty region: no origin offset
              out_data.center_x <= '0;
              out_data.center_y <= '0;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign centroid.valid = out_valid;
  assign centroid.data  = out_data;

endmodule

`default_nettype wire

// ===== sv/dpc_checker.sv =====
// Port-level checks for dark_pixel_centroid_unit, attached by bind.
// Depends on dpc_pkg widths only.
`default_nettype none

module dpc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         in_last,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         found,
  input wire logic [dpc_pkg::CNT_W-1:0]    dark_count,
  input wire logic [dpc_pkg::CENTER_W-1:0] center_x,
  input wire logic [dpc_pkg::CENTER_W-1:0] center_y
);

  // A stalled result stays valid with its count and found flag held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dark_count) && $stable(found))
    else $error("result changed while stalled");

  // Empty region reports zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> dark_count == '0 && center_x == '0 && center_y == '0)
    else $error("empty region result not zero");

  a_found_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> dark_count != '0)
    else $error("found set with zero count");

  // Closing a region occupies the block
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("pixel taken right after last pixel");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dark_pixel_centroid_unit dpc_checker u_dpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pixels.valid),
  .in_ready   (pixels.ready),
  .in_last    (pixels.data.last_pixel),
  .out_valid  (centroid.valid),
  .out_ready  (centroid.ready),
  .found      (centroid.data.found),
  .dark_count (centroid.data.dark_count),
  .center_x   (centroid.data.center_x),
  .center_y   (centroid.data.center_y)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for dark_pixel_centroid_unit: pixel and centroid streams,
// config write port, in-bench centroid predictor and in-order result checker.
// Depends on dpc_pkg, dpc_stream_if and the block's RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [dpc_pkg::CFG_IDX_W-1:0] REG_UNUSED = dpc_pkg::CFG_IDX_W'(3);
  // Divider runs twice after the last pixel; leave headroom.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int IDLE_PCT      = 18;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data;

  dpc_stream_if #(.payload_t(dpc_pkg::pixel_t))    pix_if ();
  dpc_stream_if #(.payload_t(dpc_pkg::centroid_t)) cen_if ();

  dark_pixel_centroid_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_if),
    .centroid  (cen_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register copies and the running dark-pixel sums
  // ---------------------------------------------------------------------------
  logic [dpc_pkg::PIX_W-1:0]    cfg_thresh;
  logic [dpc_pkg::ORIGIN_W-1:0] cfg_ox;
  logic [dpc_pkg::ORIGIN_W-1:0] cfg_oy;
  logic [dpc_pkg::SUM_W-1:0]    dark_col_sum;
  logic [dpc_pkg::SUM_W-1:0]    dark_row_sum;
  logic [dpc_pkg::CNT_W-1:0]    dark_hits;

  dpc_pkg::centroid_t pending_centroids[$];   // expected results, oldest first
  int                 errors;

  // Both sides idle at random unless this is set (no-idle stretch).
  bit steady;
  // Receiver hold-off requests: the test bumps hold_asked, receiver counts.
  int unsigned hold_asked;
  int unsigned hold_done;
  int unsigned hold_len;

  // Fold one accepted pixel into the sums; on the last pixel queue a centroid.
  function automatic void take_pixel(input dpc_pkg::pixel_t p);
    dpc_pkg::centroid_t c;
    if (p.pixel_value < cfg_thresh && p.col_in_region < dpc_pkg::REGION_SIDE &&
        p.row_in_region < dpc_pkg::REGION_SIDE && dark_hits < dpc_pkg::MAX_HITS) begin
      dark_col_sum = dark_col_sum + dpc_pkg::SUM_W'(p.col_in_region);
      dark_row_sum = dark_row_sum + dpc_pkg::SUM_W'(p.row_in_region);
      dark_hits    = dark_hits + 1'b1;
    end
    if (p.last_pixel) begin
      if (dark_hits != 0) begin
        // truncating divide, then shift into frame coordinates
        c.center_x   = dpc_pkg::CENTER_W'(int'(dark_col_sum) / int'(dark_hits) +
                                          int'(cfg_ox));
        c.center_y   = dpc_pkg::CENTER_W'(int'(dark_row_sum) / int'(dark_hits) +
                                          int'(cfg_oy));
        c.found      = 1'b1;
        c.dark_count = dark_hits;
      end else begin
        // nothing dark: zeros, origin not added
        c = '0;
      end
      pending_centroids = {pending_centroids, c};
      dark_col_sum = '0;
      dark_row_sum = '0;
      dark_hits    = '0;
    end
  endfunction

  function automatic dpc_pkg::pixel_t pix(input int v, input int c, input int r,
                                          input bit l);
    dpc_pkg::pixel_t p;
    p.pixel_value   = dpc_pkg::PIX_W'(v);
    p.col_in_region = dpc_pkg::COORD_W'(c);
    p.row_in_region = dpc_pkg::COORD_W'(r);
    p.last_pixel    = l;
    return p;
  endfunction

  // Random pixel; about half drawn at or below the threshold so both dark
  // and bright pixels show up at any threshold above 0.
  function automatic dpc_pkg::pixel_t rand_pixel(input bit l);
    int v;
    v = ($urandom_range(99) < 55) ? $urandom_range(255) : $urandom_range(cfg_thresh);
    return pix(v, $urandom_range(dpc_pkg::REGION_SIDE - 1),
               $urandom_range(dpc_pkg::REGION_SIDE - 1), l);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("%0t ns: timeout, %0d centroids still pending", $time,
             pending_centroids.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Centroid side: random ready, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left    = 0;
    cen_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        cen_if.ready <= 1'b0;
      end else begin
        cen_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Every centroid transfer is matched against the oldest expectation.
  // Sampled at the edge, so the values seen are the ones the transfer used.
  always @(posedge clk) begin
    dpc_pkg::centroid_t want;
    if (!rst && cen_if.valid && cen_if.ready) begin
      if (pending_centroids.size() == 0) begin
        $display("%0t ns: unexpected centroid, expected none, got %p", $time,
                 cen_if.data);
        errors++;
      end else begin
        want = pending_centroids.pop_front();
        check_field("center_x",   16'(want.center_x),   16'(cen_if.data.center_x));
        check_field("center_y",   16'(want.center_y),   16'(cen_if.data.center_y));
        check_field("found",      16'(want.found),      16'(cen_if.data.found));
        check_field("dark_count", 16'(want.dark_count), 16'(cen_if.data.dark_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side and config port
  // ---------------------------------------------------------------------------

  // One pixel transfer. Idle gaps come first, so valid only drops between
  // items and never gets two updates in one step. Prediction at acceptance.
  task automatic send_pixel(input dpc_pkg::pixel_t p);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        pix_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    pix_if.valid <= 1'b1;
    pix_if.data  <= p;
    do @(posedge clk); while (!pix_if.ready);
    take_pixel(p);
  endtask

  task automatic send_region(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_pixel(rand_pixel(i == len - 1));
    end
  endtask

  // Sender pause: stop offering, wait for every pending centroid, then let
  // the divider settle so the block is idle.
  task automatic drain();
    int guard;
    guard = 0;
    pix_if.valid <= 1'b0;
    while (pending_centroids.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_centroids.size() != 0) begin
      $display("%0t ns: %0d centroids never arrived", $time, pending_centroids.size());
      errors++;
      pending_centroids.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dpc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dpc_pkg::REG_THRESHOLD: cfg_thresh = val[dpc_pkg::PIX_W-1:0];
      dpc_pkg::REG_ORIGIN_X:  cfg_ox     = val[dpc_pkg::ORIGIN_W-1:0];
      dpc_pkg::REG_ORIGIN_Y:  cfg_oy     = val[dpc_pkg::ORIGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic request_hold(input int unsigned cycles);
    hold_len = cycles;
    hold_asked++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: threshold 2, origin (0,0).
  task automatic test_reset_config();
    // dark at both corners, threshold value itself is bright; (0+63)/2 = 31
    send_pixel(pix(1, 0, 0, 0));
    send_pixel(pix(0, 63, 63, 0));
    send_pixel(pix(2, 10, 10, 0));
    send_pixel(pix(255, 5, 5, 1));
    // no dark pixel: zeros and found clear
    send_pixel(pix(2, 1, 1, 0));
    send_pixel(pix(200, 3, 3, 1));
    // single-pixel region, last pixel dark: it counts before the divide
    send_pixel(pix(0, 63, 0, 1));
    drain();
  endtask

  task automatic test_config_extremes();
    // threshold 0: nothing is dark, not even value 0
    write_reg(dpc_pkg::REG_THRESHOLD, 10'd0);
    send_pixel(pix(0, 5, 5, 0));
    send_pixel(pix(0, 7, 7, 1));
    drain();
    // upper data bits dropped for the threshold; origins at their top
    write_reg(dpc_pkg::REG_THRESHOLD, 10'h3FF);
    write_reg(dpc_pkg::REG_ORIGIN_X, 10'h3FF);
    write_reg(dpc_pkg::REG_ORIGIN_Y, 10'h3FF);
    send_pixel(pix(254, 63, 63, 0));
    send_pixel(pix(255, 0, 0, 0));
    send_pixel(pix(254, 63, 62, 1));   // row sum 125 / 2 truncates to 62
    drain();
    // write to an unused index must leave every register alone
    write_reg(REG_UNUSED, 10'h000);
    write_reg(dpc_pkg::REG_THRESHOLD, 10'h180);
    write_reg(dpc_pkg::REG_ORIGIN_X, 10'h2AA);
    write_reg(dpc_pkg::REG_ORIGIN_Y, 10'h155);
    write_reg(REG_UNUSED, 10'h3FF);
    send_pixel(pix(127, 1, 2, 0));
    send_pixel(pix(128, 9, 9, 0));
    send_pixel(pix(0, 2, 3, 1));
    drain();
  endtask

  // Long region: many dark pixels on the far column so the sums grow large,
  // then bright pixels that must not move them, closed by a bright last pixel.
  task automatic test_long_region();
    write_reg(dpc_pkg::REG_THRESHOLD, 10'd255);
    write_reg(dpc_pkg::REG_ORIGIN_X, 10'd17);
    write_reg(dpc_pkg::REG_ORIGIN_Y, 10'd900);
    for (int i = 0; i < 100; i++) begin
      send_pixel(pix($urandom_range(254), 63, $urandom_range(63), 0));
    end
    for (int i = 0; i < 20; i++) begin
      send_pixel(pix(255, 0, 0, 0));
    end
    send_pixel(pix(255, 0, 0, 1));
    drain();
  endtask

  // Receiver holds off while the sender keeps offering short regions, so
  // the output register and the sequencer fill and pixel ready drops.
  task automatic test_output_stall();
    write_reg(dpc_pkg::REG_THRESHOLD, 10'd200);
    write_reg(dpc_pkg::REG_ORIGIN_X, 10'd3);
    write_reg(dpc_pkg::REG_ORIGIN_Y, 10'd5);
    steady = 1'b1;
    request_hold(300);
    for (int i = 0; i < 10; i++) begin
      send_region(2);
    end
    steady = 1'b0;
    drain();
  endtask

  // Random regions over several register settings. One phase runs with no
  // idling, one with a long receiver hold-off, one with sender pauses.
  task automatic test_random_regions();
    int unsigned sent;
    int unsigned goal;
    int unsigned len;
    logic [dpc_pkg::CFG_DATA_W-1:0] thr;
    logic [dpc_pkg::CFG_DATA_W-1:0] ox;
    logic [dpc_pkg::CFG_DATA_W-1:0] oy;
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          thr = 10'd128;
          ox  = 10'd0;
          oy  = 10'd0;
        end
        1: begin
          thr = 10'h3FF;
          ox  = 10'd1023;
          oy  = 10'd1023;
        end
        default: begin
          thr = dpc_pkg::CFG_DATA_W'($urandom_range(1023));
          ox  = dpc_pkg::CFG_DATA_W'($urandom_range(1023));
          oy  = dpc_pkg::CFG_DATA_W'($urandom_range(1023));
        end
      endcase
      write_reg(dpc_pkg::REG_THRESHOLD, thr);
      write_reg(dpc_pkg::REG_ORIGIN_X, ox);
      write_reg(dpc_pkg::REG_ORIGIN_Y, oy);
      steady = (phase == 2);
      if (phase == 3) begin
        request_hold(400);
      end
      goal = sent + 95;
      while (sent < goal) begin
        // mostly short regions, now and then a long one
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
        send_region(len);
        sent += len;
        if (phase == 4 && $urandom_range(4) == 0) begin
          drain();
        end
      end
      steady = 1'b0;
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = dpc_pkg::REG_THRESHOLD;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.data  = '0;
    steady       = 1'b0;
    hold_asked   = 0;
    hold_done    = 0;
    hold_len     = 0;
    errors       = 0;
    cfg_thresh   = dpc_pkg::THRESH_RESET;
    cfg_ox       = '0;
    cfg_oy       = '0;
    dark_col_sum = '0;
    dark_row_sum = '0;
    dark_hits    = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_config_extremes();
    test_output_stall();
    test_long_region();
    test_random_regions();

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
